// ===== rtl/core/oqpf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oqpf_pkg
// shared sizes, request codes and controller/datapath signal groups
// ---------------------------------------------------------------------------
package oqpf_pkg;

   localparam int MAX_ORDERS = 64;
   localparam int IDX_W      = $clog2(MAX_ORDERS);
   localparam int CNT_W      = $clog2(MAX_ORDERS + 1);
   localparam int OUT_CNT_W  = 7;
   localparam int REQ_DATA_W = 304;
   localparam int RSP_DATA_W = 264;

   localparam logic [2:0] REQ_TRACK  = 3'd0;
   localparam logic [2:0] REQ_CANCEL = 3'd1;
   localparam logic [2:0] REQ_EXEC   = 3'd2;
   localparam logic [2:0] REQ_QUERY  = 3'd3;
   localparam logic [2:0] REQ_CLEAR  = 3'd4;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic fill;
      logic commit;
      logic load_single;
      logic emit_rd;
      logic emit_ld;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] req;
      logic       scan_done;
      logic       best_found;
      logic       nfill_nz;
      logic       out_free;
      logic       emit_last;
   } dp_stat_type;

endpackage

// ===== rtl/core/oqpf_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oqpf_ctrl
// request sequencer: table sweeps, priority picks, fills and result output
// ---------------------------------------------------------------------------
module oqpf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  oqpf_pkg::dp_stat_type stat,
   output oqpf_pkg::dp_cmd_type  cmd
);
   import oqpf_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_SCAN    = 8'b0000_0010,
      S_FILL    = 8'b0000_0100,
      S_UPD     = 8'b0000_1000,
      S_SINGLE  = 8'b0001_0000,
      S_EMIT_RD = 8'b0010_0000,
      S_EMIT_LD = 8'b0100_0000,
      S_SPARE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture    = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               if (stat.req == REQ_EXEC && stat.best_found) begin
                  state_in = S_FILL;
               end else if (stat.req == REQ_EXEC && stat.nfill_nz) begin
                  state_in = S_EMIT_RD;
               end else begin
                  state_in = S_UPD;
               end
            end
         end
         S_FILL: begin
            cmd.fill       = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_UPD: begin
            cmd.commit = 1'b1;
            state_in   = S_SINGLE;
         end
         S_SINGLE: begin
            if (stat.out_free) begin
               cmd.load_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (stat.out_free) begin
               cmd.emit_ld = 1'b1;
               state_in    = stat.emit_last ? S_IDLE : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/oqpf_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oqpf_datapath
// order table, sweep unit, fill arithmetic, fill buffer and result register
// ---------------------------------------------------------------------------
module oqpf_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [oqpf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [2:0]                        req_tuser,
   input  oqpf_pkg::dp_cmd_type              cmd,
   output oqpf_pkg::dp_stat_type             stat,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [oqpf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import oqpf_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORDERS - 1);

   // request fields
   logic [31:0]        in_id, in_qty, in_base;
   logic               in_side, in_hist;
   logic signed [31:0] in_price;
   logic [47:0]        in_seq;
   logic [62:0]        in_time, in_match;

   assign in_id    = req_tdata[31:0];
   assign in_side  = req_tdata[32];
   assign in_price = req_tdata[64:33];
   assign in_qty   = req_tdata[96:65];
   assign in_base  = req_tdata[128:97];
   assign in_seq   = req_tdata[176:129];
   assign in_hist  = req_tdata[177];
   assign in_time  = req_tdata[240:178];
   assign in_match = req_tdata[303:241];

   logic [2:0]         req_ff;
   logic [31:0]        id_ff, qty_ff, avail_ff;
   logic               side_ff;
   logic signed [31:0] price_ff;
   logic [47:0]        seq_ff;
   logic [62:0]        time_ff, match_ff;

   // table state
   logic [MAX_ORDERS-1:0] valid_ff, active_ff, cand_ff;
   logic [CNT_W-1:0]      total_ff, nfill_ff;

   logic [31:0]        mem_id    [MAX_ORDERS];
   logic               mem_side  [MAX_ORDERS];
   logic signed [31:0] mem_price [MAX_ORDERS];
   logic [47:0]        mem_seq   [MAX_ORDERS];
   logic [31:0]        mem_rem   [MAX_ORDERS];
   logic [31:0]        mem_ahead [MAX_ORDERS];

   logic [31:0]        fb_id    [MAX_ORDERS];
   logic signed [31:0] fb_price [MAX_ORDERS];
   logic [31:0]        fb_qty   [MAX_ORDERS];

   // sweep unit
   logic [IDX_W-1:0]   addr_ff, rd_idx_ff;
   logic               issue_ff, rd_vld_ff, scan_done_ff;
   logic [31:0]        rd_id_ff, rd_rem_ff, rd_ahead_ff;
   logic               rd_side_ff;
   logic signed [31:0] rd_price_ff;
   logic [47:0]        rd_seq_ff;

   logic               hit_ff, free_ff, best_ff;
   logic [IDX_W-1:0]   hit_idx_ff, free_idx_ff, best_idx_ff;
   logic [31:0]        hit_ahead_ff, sum_ff;
   logic [31:0]        best_id_ff, best_rem_ff, best_ahead_ff;
   logic signed [31:0] best_price_ff;
   logic [47:0]        best_seq_ff;

   logic [IDX_W-1:0]   emit_idx_ff;
   logic [31:0]        fb_rd_id_ff, fb_rd_qty_ff;
   logic signed [31:0] fb_rd_price_ff;

   logic               res_ok_ff;
   logic [31:0]        res_ahead_ff;

   // sweep evaluation
   logic        ent_live, same_lvl, exe_tt, exe_eq, elig, better, emit_last;
   logic [32:0] sum_add;
   logic [31:0] sum_sat;

   assign ent_live = valid_ff[rd_idx_ff] && active_ff[rd_idx_ff];
   assign same_lvl = (rd_side_ff == side_ff) && (rd_price_ff == price_ff);
   assign sum_add  = {1'b0, sum_ff} + {1'b0, rd_rem_ff};
   assign sum_sat  = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
   assign exe_tt   = side_ff ? (price_ff > rd_price_ff) : (price_ff < rd_price_ff);
   assign exe_eq   = (price_ff == rd_price_ff);
   assign elig     = cand_ff[rd_idx_ff] && (rd_side_ff == side_ff) && (exe_tt || exe_eq);

   always_comb begin
      if (rd_price_ff != best_price_ff) begin
         better = side_ff ? (rd_price_ff < best_price_ff) : (rd_price_ff > best_price_ff);
      end else if (rd_seq_ff != best_seq_ff) begin
         better = rd_seq_ff < best_seq_ff;
      end else begin
         better = rd_id_ff < best_id_ff;
      end
   end

   // fill arithmetic on the picked order
   logic        b_tt, lvl_ok;
   logic [31:0] used, ahead_sub, left_raw, left_q, fq, ahead_new, rem_new;

   always_comb begin
      b_tt      = side_ff ? (price_ff > best_price_ff) : (price_ff < best_price_ff);
      used      = (best_ahead_ff < qty_ff) ? best_ahead_ff : qty_ff;
      ahead_sub = best_ahead_ff - used;
      left_raw  = qty_ff - used;
      left_q    = (left_raw > avail_ff) ? avail_ff : left_raw;
      lvl_ok    = (ahead_sub == 32'd0) && (avail_ff != 32'd0) && (qty_ff > used);
      if (b_tt) begin
         ahead_new = 32'd0;
         fq        = (best_rem_ff < avail_ff) ? best_rem_ff : avail_ff;
      end else begin
         ahead_new = ahead_sub;
         fq        = lvl_ok ? ((best_rem_ff < left_q) ? best_rem_ff : left_q) : 32'd0;
      end
      rem_new = best_rem_ff - fq;
   end

   logic fill_hit;
   assign fill_hit = cmd.fill && (fq != 32'd0);

   // request decode for commit
   logic pre_ok, trk_ok, can_ok, exec_go;

   assign pre_ok  = (id_ff != 32'd0) && (price_ff > 32'sd0) && (qty_ff != 32'd0);
   assign trk_ok  = pre_ok && !hit_ff && free_ff;
   assign can_ok  = hit_ff && active_ff[hit_idx_ff];
   assign exec_go = (req_tuser == REQ_EXEC) && (total_ff != '0) && (in_qty != 32'd0) && in_hist;

   // captured request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff   <= req_tuser;
         id_ff    <= in_id;
         side_ff  <= in_side;
         price_ff <= in_price;
         qty_ff   <= in_qty;
         seq_ff   <= in_seq;
         time_ff  <= in_time;
         match_ff <= in_match;
      end
   end

   // table flags and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         active_ff <= '0;
         cand_ff   <= '0;
         total_ff  <= '0;
         nfill_ff  <= '0;
      end else begin
         if (cmd.capture) begin
            cand_ff  <= exec_go ? (valid_ff & active_ff) : '0;
            nfill_ff <= '0;
         end
         if (cmd.commit) begin
            unique case (req_ff)
               REQ_TRACK: begin
                  if (trk_ok) begin
                     valid_ff[free_idx_ff]  <= 1'b1;
                     active_ff[free_idx_ff] <= 1'b1;
                     total_ff               <= total_ff + CNT_W'(1);
                  end
               end
               REQ_CANCEL: begin
                  if (can_ok) begin
                     active_ff[hit_idx_ff] <= 1'b0;
                     total_ff              <= total_ff - CNT_W'(1);
                  end
               end
               REQ_CLEAR: begin
                  valid_ff  <= '0;
                  active_ff <= '0;
                  total_ff  <= '0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.fill) begin
            cand_ff[best_idx_ff] <= 1'b0;
            if (fill_hit) begin
               nfill_ff <= nfill_ff + CNT_W'(1);
               if (rem_new == 32'd0) begin
                  active_ff[best_idx_ff] <= 1'b0;
                  total_ff               <= total_ff - CNT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         avail_ff <= in_qty;
      end else if (cmd.fill) begin
         avail_ff <= avail_ff - fq;
      end
   end

   // order table memories
   always_ff @(posedge clock) begin
      if (cmd.commit && req_ff == REQ_TRACK && trk_ok) begin
         mem_id[free_idx_ff]    <= id_ff;
         mem_side[free_idx_ff]  <= side_ff;
         mem_price[free_idx_ff] <= price_ff;
         mem_seq[free_idx_ff]   <= seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && req_ff == REQ_TRACK && trk_ok) begin
         mem_rem[free_idx_ff]   <= qty_ff;
         mem_ahead[free_idx_ff] <= sum_ff;
      end else if (cmd.fill) begin
         mem_rem[best_idx_ff]   <= rem_new;
         mem_ahead[best_idx_ff] <= ahead_new;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_ff) begin
         rd_id_ff    <= mem_id[addr_ff];
         rd_side_ff  <= mem_side[addr_ff];
         rd_price_ff <= mem_price[addr_ff];
         rd_seq_ff   <= mem_seq[addr_ff];
         rd_rem_ff   <= mem_rem[addr_ff];
         rd_ahead_ff <= mem_ahead[addr_ff];
      end
   end

   // sweep address and evaluation
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         scan_done_ff <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         best_ff      <= 1'b0;
      end else begin
         rd_vld_ff    <= issue_ff;
         rd_idx_ff    <= addr_ff;
         scan_done_ff <= rd_vld_ff && (rd_idx_ff == LAST_IDX);
         if (cmd.scan_start) begin
            addr_ff  <= '0;
            issue_ff <= 1'b1;
            hit_ff   <= 1'b0;
            free_ff  <= 1'b0;
            best_ff  <= 1'b0;
         end else begin
            if (issue_ff) begin
               addr_ff <= addr_ff + IDX_W'(1);
               if (addr_ff == LAST_IDX) begin
                  issue_ff <= 1'b0;
               end
            end
            if (rd_vld_ff) begin
               if (valid_ff[rd_idx_ff] && rd_id_ff == id_ff) begin
                  hit_ff       <= 1'b1;
                  hit_idx_ff   <= rd_idx_ff;
                  hit_ahead_ff <= rd_ahead_ff;
               end
               if (!valid_ff[rd_idx_ff] && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= rd_idx_ff;
               end
               if (elig && (!best_ff || better)) begin
                  best_ff       <= 1'b1;
                  best_idx_ff   <= rd_idx_ff;
                  best_id_ff    <= rd_id_ff;
                  best_price_ff <= rd_price_ff;
                  best_seq_ff   <= rd_seq_ff;
                  best_rem_ff   <= rd_rem_ff;
                  best_ahead_ff <= rd_ahead_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sum_ff <= in_base;
      end else if (rd_vld_ff && ent_live && same_lvl) begin
         sum_ff <= sum_sat;
      end
   end

   // fill buffer
   always_ff @(posedge clock) begin
      if (fill_hit) begin
         fb_id[nfill_ff[IDX_W-1:0]]    <= best_id_ff;
         fb_price[nfill_ff[IDX_W-1:0]] <= best_price_ff;
         fb_qty[nfill_ff[IDX_W-1:0]]   <= fq;
      end
      if (cmd.emit_rd) begin
         fb_rd_id_ff    <= fb_id[emit_idx_ff];
         fb_rd_price_ff <= fb_price[emit_idx_ff];
         fb_rd_qty_ff   <= fb_qty[emit_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_idx_ff <= '0;
      end else if (cmd.capture) begin
         emit_idx_ff <= '0;
      end else if (cmd.emit_ld) begin
         emit_idx_ff <= emit_idx_ff + IDX_W'(1);
      end
   end

   assign emit_last = (CNT_W'(emit_idx_ff) == (nfill_ff - CNT_W'(1)));

   // single result status
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_ahead_ff <= 32'd0;
         unique case (req_ff)
            REQ_TRACK:  res_ok_ff <= trk_ok;
            REQ_CANCEL: res_ok_ff <= can_ok;
            REQ_EXEC:   res_ok_ff <= 1'b1;
            REQ_QUERY: begin
               res_ok_ff    <= hit_ff;
               res_ahead_ff <= hit_ff ? hit_ahead_ff : 32'd0;
            end
            REQ_CLEAR:  res_ok_ff <= 1'b1;
            default:    res_ok_ff <= 1'b0;
         endcase
      end
   end

   // result register
   logic               rsp_valid_ff, o_ok_ff, o_fill_ff, o_side_ff, o_last_ff;
   logic [31:0]        o_id_ff, o_qty_ff, o_ahead_ff;
   logic signed [31:0] o_price_ff;
   logic [62:0]        o_time_ff, o_match_ff;
   logic [OUT_CNT_W-1:0] o_cnt_ff;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_single || cmd.emit_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_single) begin
         o_ok_ff    <= res_ok_ff;
         o_fill_ff  <= 1'b0;
         o_id_ff    <= 32'd0;
         o_side_ff  <= 1'b0;
         o_price_ff <= 32'sd0;
         o_qty_ff   <= 32'd0;
         o_time_ff  <= 63'd0;
         o_match_ff <= 63'd0;
         o_ahead_ff <= res_ahead_ff;
         o_cnt_ff   <= OUT_CNT_W'(total_ff);
         o_last_ff  <= 1'b1;
      end else if (cmd.emit_ld) begin
         o_ok_ff    <= 1'b1;
         o_fill_ff  <= 1'b1;
         o_id_ff    <= fb_rd_id_ff;
         o_side_ff  <= side_ff;
         o_price_ff <= fb_rd_price_ff;
         o_qty_ff   <= fb_rd_qty_ff;
         o_time_ff  <= time_ff;
         o_match_ff <= match_ff;
         o_ahead_ff <= 32'd0;
         o_cnt_ff   <= OUT_CNT_W'(total_ff);
         o_last_ff  <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = o_fill_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {1'b0, o_cnt_ff, o_ahead_ff, o_match_ff, o_time_ff, o_qty_ff,
                        o_price_ff, o_side_ff, o_id_ff, o_ok_ff};

   assign stat.req        = req_ff;
   assign stat.scan_done  = scan_done_ff;
   assign stat.best_found = best_ff;
   assign stat.nfill_nz   = (nfill_ff != '0);
   assign stat.out_free   = out_free;
   assign stat.emit_last  = emit_last;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_ORDERS)) else $error("active count above table size");
   a_active_valid: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~valid_ff) == '0) else $error("active entry without valid slot");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      scan_done_ff |=> !scan_done_ff) else $error("sweep done held");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      nfill_ff <= CNT_W'(MAX_ORDERS)) else $error("fill count above table size");

endmodule

// ===== rtl/core/order_queue_position_fill_tracker_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// order_queue_position_fill_tracker_top
// Tracks simulated resting orders and their queue position, and turns
// historical executions into fills in price-time priority. Every request
// sweeps the 64-entry order table through one memory read port. Track,
// cancel, query, clear and unknown codes then commit and load their one
// result. An execute adds one sweep per picked order, one for each same-side
// order at or through the price. Each fill is then read from the fill buffer
// and loaded into the output register, or a single result is loaded when
// nothing fills, waiting on any output stall. The next request is taken
// once the last result sits in the output register.
// ---------------------------------------------------------------------------
module order_queue_position_fill_tracker_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // order_id, side, price, quantity, base_ahead, book_seq, hist_present,
   // event_time, match_num
   input  logic [oqpf_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // ok, out_order_id, out_side, out_price, out_qty, out_time, out_match,
   // out_ahead, out_active_count, pad
   output logic [oqpf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // is_fill
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import oqpf_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   oqpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   oqpf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/sv/order_queue_position_fill_tracker_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// order_queue_position_fill_tracker_top_test
// Drives track, cancel, execute, query, clear and unused requests into the
// order tracker and checks every result transfer against an in-bench order
// book that predicts fills in price-time priority. Directed cases first,
// then random order flow. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module order_queue_position_fill_tracker_top_test;
   import oqpf_pkg::*;

   localparam int IDLE_PCT  = 34;
   localparam int STALL_MAX = 20000;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] id;
      logic        side;
      logic [31:0] price;
      logic [31:0] qty;
      logic [31:0] base;
      logic [47:0] seq;
      logic        hist;
      logic [62:0] t;
      logic [62:0] m;
   } order_req_type;

   typedef struct {
      logic        ok;
      logic        fill;
      logic [31:0] id;
      logic        side;
      logic [31:0] price;
      logic [31:0] qty;
      logic [62:0] t;
      logic [62:0] m;
      logic [31:0] ahead;
      logic [6:0]  cnt;
      logic        last;
   } book_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [2:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   order_queue_position_fill_tracker_top dut (.*);

   // order book copy
   logic        bk_valid [MAX_ORDERS];
   logic        bk_active[MAX_ORDERS];
   logic [31:0] bk_id    [MAX_ORDERS];
   logic        bk_side  [MAX_ORDERS];
   logic [31:0] bk_price [MAX_ORDERS];
   logic [31:0] bk_rem   [MAX_ORDERS];
   logic [31:0] bk_ahead [MAX_ORDERS];
   logic [47:0] bk_seq   [MAX_ORDERS];
   int          bk_count;

   book_rsp_type pending_rsp[$];
   int           errors;
   int           stall_cnt;
   bit           steady;
   logic [47:0]  seq_ctr;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int find_order(logic [31:0] id);
      for (int i = 0; i < MAX_ORDERS; i++)
         if (bk_valid[i] && bk_id[i] == id) return i;
      return -1;
   endfunction

   function automatic bit precedes(int a, int b);
      if (bk_side[a] != bk_side[b]) return bk_side[a] == 1'b0;
      if (bk_price[a] != bk_price[b])
         return bk_side[a] == 1'b0 ? $signed(bk_price[a]) > $signed(bk_price[b])
                                   : $signed(bk_price[a]) < $signed(bk_price[b]);
      if (bk_seq[a] != bk_seq[b]) return bk_seq[a] < bk_seq[b];
      return bk_id[a] < bk_id[b];
   endfunction

   function automatic void book_apply(order_req_type r);
      book_rsp_type res[$];
      book_rsp_type x;
      bit           cand[MAX_ORDERS];
      int           slot;
      int           e;
      int           b;
      logic [32:0]  acc;
      logic [31:0]  avail;
      logic [31:0]  fq;
      logic [31:0]  used;
      logic [31:0]  left;
      x = '{default: '0};
      case (r.kind)
         REQ_TRACK: begin
            slot = -1;
            x.ok = r.id != 0 && $signed(r.price) > 0 && r.qty != 0 && find_order(r.id) < 0;
            if (x.ok) begin
               for (int i = MAX_ORDERS - 1; i >= 0; i--)
                  if (!bk_valid[i]) slot = i;
               x.ok = slot >= 0;
            end
            if (x.ok) begin
               acc = {1'b0, r.base};
               for (int i = 0; i < MAX_ORDERS; i++)
                  if (bk_valid[i] && bk_active[i] && bk_side[i] == r.side &&
                      bk_price[i] == r.price) begin
                     acc = acc + {1'b0, bk_rem[i]};
                     if (acc[32]) acc = 33'h0FFFFFFFF;
                  end
               bk_valid[slot] = 1'b1; bk_active[slot] = 1'b1; bk_id[slot] = r.id;
               bk_side[slot] = r.side; bk_price[slot] = r.price;
               bk_rem[slot] = r.qty; bk_ahead[slot] = acc[31:0];
               bk_seq[slot] = r.seq; bk_count++;
            end
            res = {res, x};
         end
         REQ_CANCEL: begin
            e = find_order(r.id);
            x.ok = e >= 0 && bk_active[e];
            if (x.ok) begin
               bk_active[e] = 1'b0; bk_count--;
            end
            res = {res, x};
         end
         REQ_EXEC: begin
            if (bk_count != 0 && r.qty != 0 && r.hist) begin
               avail = r.qty;
               for (int i = 0; i < MAX_ORDERS; i++) cand[i] = bk_valid[i] && bk_active[i];
               while (1) begin
                  b = -1;
                  for (int i = 0; i < MAX_ORDERS; i++)
                     if (cand[i] && (b < 0 || precedes(i, b))) b = i;
                  if (b < 0) break;
                  cand[b] = 1'b0;
                  if (!bk_active[b] || bk_side[b] != r.side) continue;
                  fq = '0;
                  if ((r.side == 1'b0 && $signed(r.price) < $signed(bk_price[b])) ||
                      (r.side == 1'b1 && $signed(r.price) > $signed(bk_price[b]))) begin
                     bk_ahead[b] = '0;
                     fq = bk_rem[b] < avail ? bk_rem[b] : avail;
                  end else if (r.price == bk_price[b]) begin
                     used = bk_ahead[b] < r.qty ? bk_ahead[b] : r.qty;
                     bk_ahead[b] -= used;
                     if (bk_ahead[b] == 0 && avail > 0 && r.qty > used) begin
                        left = r.qty - used;
                        if (left > avail) left = avail;
                        fq = bk_rem[b] < left ? bk_rem[b] : left;
                     end
                  end
                  if (fq > 0) begin
                     bk_rem[b] -= fq;
                     avail -= fq;
                     x = '{ok: 1'b1, fill: 1'b1, id: bk_id[b], side: bk_side[b],
                           price: bk_price[b], qty: fq, t: r.t, m: r.m, default: '0};
                     res = {res, x};
                     if (bk_rem[b] == 0) begin
                        bk_active[b] = 1'b0; bk_count--;
                     end
                  end
               end
            end
            if (res.size() == 0) begin
               x = '{default: '0};
               x.ok = 1'b1;
               res = {res, x};
            end
         end
         REQ_QUERY: begin
            e = find_order(r.id);
            x.ok = e >= 0;
            if (e >= 0) x.ahead = bk_ahead[e];
            res = {res, x};
         end
         REQ_CLEAR: begin
            for (int i = 0; i < MAX_ORDERS; i++) begin
               bk_valid[i] = 1'b0; bk_active[i] = 1'b0;
            end
            bk_count = 0;
            x.ok = 1'b1;
            res = {res, x};
         end
         default: res = {res, x};
      endcase
      foreach (res[k]) begin
         res[k].cnt  = bk_count[6:0];
         res[k].last = k == res.size() - 1;
         pending_rsp = {pending_rsp, res[k]};
      end
   endfunction

   task automatic send_request(order_req_type r);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {r.m, r.t, r.hist, r.seq, r.base, r.qty, r.price, r.side, r.id};
      do @(posedge clock); while (!req_tready);
      book_apply(r);
   endtask

   function automatic order_req_type mk(logic [2:0] kind, logic [31:0] id,
                                        logic [31:0] side, logic [31:0] price,
                                        logic [31:0] qty, logic [31:0] base,
                                        logic [31:0] hist);
      order_req_type r;
      r.kind = kind; r.id = id; r.side = side[0]; r.price = price; r.qty = qty;
      r.base = base; r.hist = hist[0];
      seq_ctr++;
      r.seq = seq_ctr;
      r.t = 63'({$urandom, $urandom});
      r.m = 63'({$urandom, $urandom});
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      book_rsp_type x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected transfer expected none actual %0h", $time, rsp_tdata);
         end else begin
            x = pending_rsp.pop_front();
            check_field("ok", 64'(x.ok), 64'(rsp_tdata[0]));
            check_field("is_fill", 64'(x.fill), 64'(rsp_tuser));
            check_field("order_id", 64'(x.id), 64'(rsp_tdata[32:1]));
            check_field("side", 64'(x.side), 64'(rsp_tdata[33]));
            check_field("price", 64'(x.price), 64'(rsp_tdata[65:34]));
            check_field("qty", 64'(x.qty), 64'(rsp_tdata[97:66]));
            check_field("time", 64'(x.t), 64'(rsp_tdata[160:98]));
            check_field("match", 64'(x.m), 64'(rsp_tdata[223:161]));
            check_field("ahead", 64'(x.ahead), 64'(rsp_tdata[255:224]));
            check_field("active_count", 64'(x.cnt), 64'(rsp_tdata[262:256]));
            check_field("last", 64'(x.last), 64'(rsp_tlast));
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || $urandom_range(99) >= IDLE_PCT;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cnt <= 0;
      else
         stall_cnt <= stall_cnt + 1;
      if (stall_cnt > STALL_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_track_rejects();
      send_request(mk(REQ_TRACK, 0, 0, 5, 10, 0, 1));
      send_request(mk(REQ_TRACK, 1, 0, 0, 10, 0, 1));
      send_request(mk(REQ_TRACK, 1, 1, 32'h80000000, 10, 0, 1));
      send_request(mk(REQ_TRACK, 1, 0, 5, 0, 0, 1));
      send_request(mk(REQ_TRACK, 32'hFFFFFFFF, 1, 32'h7FFFFFFF, 32'hFFFFFFFF,
                      32'hFFFFFFFF, 1));
      send_request(mk(REQ_TRACK, 32'hFFFFFFFF, 0, 5, 3, 0, 1));
      send_request(mk(REQ_TRACK, 7, 1, 32'h7FFFFFFF, 9, 32'hFFFFFFF0, 1));
      send_request(mk(REQ_QUERY, 7, 0, 0, 0, 0, 0));
   endtask

   task automatic test_cancel_query();
      send_request(mk(REQ_CANCEL, 7, 0, 0, 0, 0, 0));
      send_request(mk(REQ_CANCEL, 7, 0, 0, 0, 0, 0));
      send_request(mk(REQ_CANCEL, 99, 0, 0, 0, 0, 0));
      send_request(mk(REQ_QUERY, 7, 0, 0, 0, 0, 0));
      send_request(mk(REQ_QUERY, 99, 0, 0, 0, 0, 0));
      send_request(mk(REQ_TRACK, 7, 0, 5, 1, 0, 1));
   endtask

   task automatic test_execute();
      send_request(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
      send_request(mk(REQ_EXEC, 0, 0, 10, 5, 0, 1));
      send_request(mk(REQ_TRACK, 100, 0, 10, 5, 3, 1));
      send_request(mk(REQ_TRACK, 101, 0, 10, 4, 0, 1));
      send_request(mk(REQ_TRACK, 102, 0, 12, 2, 0, 1));
      send_request(mk(REQ_TRACK, 103, 1, 20, 3, 1, 1));
      send_request(mk(REQ_EXEC, 0, 0, 9, 5, 0, 0));
      send_request(mk(REQ_EXEC, 0, 0, 9, 0, 0, 1));
      send_request(mk(REQ_EXEC, 0, 0, 11, 1, 0, 1));
      send_request(mk(REQ_EXEC, 0, 0, 10, 6, 0, 1));
      send_request(mk(REQ_QUERY, 101, 0, 0, 0, 0, 0));
      send_request(mk(REQ_EXEC, 0, 1, 21, 32'hFFFFFFFF, 0, 1));
      send_request(mk(REQ_EXEC, 0, 0, 32'h80000000, 32'hFFFFFFFF, 0, 1));
   endtask

   task automatic test_unused_codes();
      for (int k = 5; k < 8; k++) send_request(mk(k[2:0], 1, 1, 1, 1, 1, 1));
   endtask

   task automatic test_full_table();
      send_request(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
      for (int k = 0; k < MAX_ORDERS; k++)
         send_request(mk(REQ_TRACK, 500 + k, 0, $urandom_range(3, 1), 1, 0, 1));
      send_request(mk(REQ_TRACK, 999, 1, 3, 1, 0, 1));
      send_request(mk(REQ_EXEC, 0, 0, 1, 32'hFFFFFFFF, 0, 1));
      send_request(mk(REQ_TRACK, 999, 1, 3, 1, 0, 1));
      send_request(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random_flow();
      order_req_type r;
      int            pick;
      for (int k = 0; k < 111; k++) begin
         steady = k >= 40 && k < 80;
         pick = $urandom_range(99);
         r = mk(REQ_TRACK, $urandom_range(40, 1), $urandom_range(1),
                $urandom_range(7, 4), $urandom_range(20, 1), $urandom_range(30), 1);
         if ($urandom_range(9) == 0) begin
            r.id = $urandom; r.price = $urandom; r.qty = $urandom; r.base = $urandom;
            r.seq = 48'({$urandom, $urandom});
         end
         if (pick < 40) r.kind = REQ_TRACK;
         else if (pick < 50) r.kind = REQ_CANCEL;
         else if (pick < 78) begin
            r.kind = REQ_EXEC;
            r.qty  = $urandom_range(60);
            r.hist = $urandom_range(9) != 0;
            r.price = $urandom_range(8, 3);
         end else if (pick < 95) r.kind = REQ_QUERY;
         else if (pick < 98) r.kind = REQ_CLEAR;
         else r.kind = 3'($urandom_range(7, 5));
         send_request(r);
      end
      steady = 0;
   endtask

   initial begin
      errors = 0; stall_cnt = 0; steady = 0; seq_ctr = '0; bk_count = 0;
      for (int i = 0; i < MAX_ORDERS; i++) begin
         bk_valid[i] = 1'b0; bk_active[i] = 1'b0;
      end
      reset = 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_track_rejects();
      test_cancel_query();
      test_execute();
      test_unused_codes();
      test_full_table();
      test_random_flow();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/oqpf_pkg.sv
rtl/core/oqpf_ctrl.sv
rtl/core/oqpf_datapath.sv
rtl/core/order_queue_position_fill_tracker_top.sv
tb/sv/order_queue_position_fill_tracker_top_test.sv
